FILE: sv/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

   localparam int OpW     = 2;
   localparam int IndexW  = 8;
   localparam int OffsetW = 12;
   localparam int StatusW = 2;
   localparam int CountW  = 9;
   localparam int SizeW   = 13;

   localparam logic [SizeW-1:0]  MIN_BLOCK_BYTES = 13'd16;
   localparam logic [SizeW-1:0]  RESET_BLOCK_BYTES = 13'd16;
   localparam logic [CountW-1:0] COUNT_MAX = 9'd511;

   localparam logic [OpW-1:0] OP_ALLOC = 2'd0;
   localparam logic [OpW-1:0] OP_FREE  = 2'd1;
   localparam logic [OpW-1:0] OP_INIT  = 2'd2;

   localparam logic [StatusW-1:0] ST_OK    = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

   typedef enum logic [1:0] {
      FBFL_IDLE,
      FBFL_ALLOC,
      FBFL_INIT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/fbfl_ram.sv
`default_nettype none

module fbfl_ram #(
   parameter int Width = 9,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/fixed_block_free_list_allocator_top.sv
`default_nettype none

// Fixed-size block pool with a linked free list held in a single-port link
// memory. Allocate reads the link of the head, then updates the head in the
// ALLOC state; free and the unused code are answered from idle, and initialize
// walks the pool in the INIT state, writing one link entry per cycle
// through the single memory port. Results sit in an output register; while
// one is held by rsp_stall no new request is taken. csr_ready is always high.

module fixed_block_free_list_allocator_top #(
   parameter int POOL_BYTES = 4096,
   parameter int MAX_BLOCKS = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [fbfl_pkg::OpW-1:0]        req_operation,
   input  wire logic [fbfl_pkg::IndexW-1:0]     req_block_index,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [fbfl_pkg::IndexW-1:0]     rsp_given_index,
   output logic      [fbfl_pkg::OffsetW-1:0]    rsp_given_offset,
   output logic      [fbfl_pkg::StatusW-1:0]    rsp_status,
   output logic      [fbfl_pkg::CountW-1:0]     rsp_blocks_free,

   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fbfl_pkg::SizeW-1:0]      csr_block_bytes
);

   localparam int AddrW = $clog2(MAX_BLOCKS);
   localparam int LinkW = AddrW + 1;
   localparam int EndW  = $clog2(POOL_BYTES + 8192);
   localparam int CmpW  = (LinkW > fbfl_pkg::IndexW) ? LinkW : fbfl_pkg::IndexW;
   localparam int ProdW = LinkW + fbfl_pkg::SizeW;

   fbfl_pkg::state_type state_ff, state_in;

   logic [fbfl_pkg::SizeW-1:0]   size_ff;
   logic [LinkW-1:0]             head_ff, head_in;
   logic [fbfl_pkg::CountW-1:0]  free_ff, free_in;
   logic [LinkW-1:0]             total_ff, total_in;
   logic [AddrW-1:0]             walk_ff, walk_in;
   logic [EndW-1:0]              end_ff, end_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fbfl_pkg::IndexW-1:0]  rsp_index_ff, rsp_index_in;
   logic [fbfl_pkg::OffsetW-1:0] rsp_offset_ff, rsp_offset_in;
   logic [fbfl_pkg::StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [fbfl_pkg::CountW-1:0]  rsp_free_ff, rsp_free_in;

   logic                         ram_we;
   logic [AddrW-1:0]             ram_addr;
   logic [LinkW-1:0]             ram_wdata;
   logic [LinkW-1:0]             ram_rdata;

   logic [fbfl_pkg::SizeW-1:0]   eff_size;
   logic [ProdW-1:0]             prod;
   logic [EndW-1:0]              next_end;
   logic                         req_fire;
   logic                         rsp_hold;
   logic                         pool_empty;
   logic                         free_bad;
   logic                         init_none;
   logic                         walk_last;

   fbfl_ram #(
      .Width (LinkW),
      .Depth (MAX_BLOCKS)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign csr_ready = 1'b1;

   assign eff_size = (size_ff < fbfl_pkg::MIN_BLOCK_BYTES) ? fbfl_pkg::MIN_BLOCK_BYTES
                                                           : size_ff;
   assign prod     = ProdW'(head_ff) * ProdW'(eff_size);
   assign next_end = end_ff + EndW'(eff_size);

   assign rsp_hold   = rsp_valid_ff && rsp_stall;
   assign req_fire   = req_valid && !req_stall;
   assign pool_empty = (free_ff == '0) || (head_ff >= LinkW'(MAX_BLOCKS));
   assign free_bad   = (CmpW'(req_block_index) >= CmpW'(total_ff)) ||
                       (CmpW'(req_block_index) >= CmpW'(MAX_BLOCKS));
   assign init_none  = EndW'(eff_size) > EndW'(POOL_BYTES);
   assign walk_last  = (next_end > EndW'(POOL_BYTES)) ||
                       (walk_ff == AddrW'(MAX_BLOCKS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbfl_pkg::FBFL_IDLE: begin
            if (req_fire) begin
               if (req_operation == fbfl_pkg::OP_ALLOC && !pool_empty) begin
                  state_in = fbfl_pkg::FBFL_ALLOC;
               end else if (req_operation == fbfl_pkg::OP_INIT && !init_none) begin
                  state_in = fbfl_pkg::FBFL_INIT;
               end
            end
         end
         fbfl_pkg::FBFL_ALLOC: begin
            state_in = fbfl_pkg::FBFL_IDLE;
         end
         fbfl_pkg::FBFL_INIT: begin
            if (walk_last) begin
               state_in = fbfl_pkg::FBFL_IDLE;
            end
         end
         default: begin
            state_in = fbfl_pkg::FBFL_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall     = (state_ff != fbfl_pkg::FBFL_IDLE) || rsp_hold;
      ram_we        = 1'b0;
      ram_addr      = AddrW'(head_ff);
      ram_wdata     = head_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      total_in      = total_ff;
      walk_in       = walk_ff;
      end_in        = end_ff;
      rsp_valid_in  = rsp_hold;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;

      unique case (state_ff)
         fbfl_pkg::FBFL_IDLE: begin
            if (req_fire) begin
               rsp_index_in  = '0;
               rsp_offset_in = '0;
               rsp_status_in = fbfl_pkg::ST_OK;
               rsp_free_in   = free_ff;
               rsp_valid_in  = 1'b1;
               unique case (req_operation)
                  fbfl_pkg::OP_ALLOC: begin
                     if (pool_empty) begin
                        rsp_status_in = fbfl_pkg::ST_EMPTY;
                     end else begin
                        rsp_index_in  = fbfl_pkg::IndexW'(head_ff);
                        rsp_offset_in = prod[fbfl_pkg::OffsetW-1:0];
                        free_in       = free_ff - fbfl_pkg::CountW'(1);
                        rsp_free_in   = free_ff - fbfl_pkg::CountW'(1);
                     end
                  end
                  fbfl_pkg::OP_FREE: begin
                     if (free_bad) begin
                        rsp_status_in = fbfl_pkg::ST_RANGE;
                     end else begin
                        ram_we    = 1'b1;
                        ram_addr  = AddrW'(req_block_index);
                        ram_wdata = head_ff;
                        head_in   = LinkW'(req_block_index);
                        if (free_ff != fbfl_pkg::COUNT_MAX) begin
                           free_in     = free_ff + fbfl_pkg::CountW'(1);
                           rsp_free_in = free_ff + fbfl_pkg::CountW'(1);
                        end
                     end
                  end
                  fbfl_pkg::OP_INIT: begin
                     walk_in = '0;
                     end_in  = EndW'(eff_size);
                     if (init_none) begin
                        head_in     = LinkW'(MAX_BLOCKS);
                        free_in     = '0;
                        total_in    = '0;
                        rsp_free_in = '0;
                     end else begin
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         fbfl_pkg::FBFL_ALLOC: begin
            head_in = ram_rdata;
         end
         fbfl_pkg::FBFL_INIT: begin
            ram_we   = 1'b1;
            ram_addr = walk_ff;
            walk_in  = walk_ff + AddrW'(1);
            end_in   = next_end;
            if (walk_last) begin
               ram_wdata     = LinkW'(MAX_BLOCKS);
               head_in       = '0;
               total_in      = LinkW'(walk_ff) + LinkW'(1);
               free_in       = fbfl_pkg::CountW'(LinkW'(walk_ff) + LinkW'(1));
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_offset_in = '0;
               rsp_status_in = fbfl_pkg::ST_OK;
               rsp_free_in   = fbfl_pkg::CountW'(LinkW'(walk_ff) + LinkW'(1));
            end else begin
               ram_wdata = LinkW'(walk_ff) + LinkW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfl_pkg::FBFL_IDLE;
         size_ff      <= fbfl_pkg::RESET_BLOCK_BYTES;
         head_ff      <= LinkW'(MAX_BLOCKS);
         free_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_block_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      end_ff        <= end_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_given_index  = rsp_index_ff;
   assign rsp_given_offset = rsp_offset_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_blocks_free  = rsp_free_ff;

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LinkW'(MAX_BLOCKS))
      else $error("free list head beyond null marker");

   a_alloc_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbfl_pkg::FBFL_ALLOC |=> state_ff == fbfl_pkg::FBFL_IDLE)
      else $error("alloc head update did not finish in one cycle");

   a_init_writes: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbfl_pkg::FBFL_INIT |-> ram_we)
      else $error("init walk skipped a link write");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbfl_pkg::FBFL_INIT |-> req_stall && !rsp_valid_ff)
      else $error("request taken or result pending during init walk");

endmodule

`default_nettype wire

FILE: sim/fbfl_pool_shadow.sv
module fbfl_pool_shadow #(
   parameter int POOL_BYTES = 4096,
   parameter int MAX_BLOCKS = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [fbfl_pkg::OpW-1:0]     req_operation,
   input  wire logic [fbfl_pkg::IndexW-1:0]  req_block_index,

   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [fbfl_pkg::IndexW-1:0]  rsp_given_index,
   input  wire logic [fbfl_pkg::OffsetW-1:0] rsp_given_offset,
   input  wire logic [fbfl_pkg::StatusW-1:0] rsp_status,
   input  wire logic [fbfl_pkg::CountW-1:0]  rsp_blocks_free,

   input  wire logic                         csr_valid,
   input  wire logic                         csr_ready,
   input  wire logic [fbfl_pkg::SizeW-1:0]   csr_block_bytes,

   output int unsigned                       mismatch_count,
   output int unsigned                       pending_count,
   output int unsigned                       result_count
);
   import fbfl_pkg::*;

   typedef struct packed {
      logic [IndexW-1:0]  given_index;
      logic [OffsetW-1:0] given_offset;
      logic [StatusW-1:0] status;
      logic [CountW-1:0]  blocks_free;
   } pool_result_type;

   logic [SizeW-1:0]  block_bytes_reg;
   logic [CountW-1:0] link_next [MAX_BLOCKS];
   logic [CountW-1:0] head_idx;
   logic [CountW-1:0] free_blocks;
   logic [CountW-1:0] pool_blocks;
   pool_result_type   pending_results [$];

   function automatic int live_block_bytes();
      if (block_bytes_reg < MIN_BLOCK_BYTES) begin
         return int'(MIN_BLOCK_BYTES);
      end
      return int'(block_bytes_reg);
   endfunction

   task automatic pool_step(input logic [OpW-1:0] op, input logic [IndexW-1:0] idx,
                            output pool_result_type res);
      int count;
      int offset;
      int i;
      res = '0;
      case (op)
         OP_ALLOC: begin
            if (free_blocks == 0 || int'(head_idx) >= MAX_BLOCKS) begin
               res.status = ST_EMPTY;
            end else begin
               offset           = int'(head_idx) * live_block_bytes();
               res.given_index  = head_idx[IndexW-1:0];
               res.given_offset = offset[OffsetW-1:0];
               head_idx         = link_next[head_idx];
               free_blocks      = free_blocks - CountW'(1);
            end
         end
         OP_FREE: begin
            if ({1'b0, idx} >= pool_blocks) begin
               res.status = ST_RANGE;
            end else begin
               link_next[idx] = head_idx;
               head_idx       = {1'b0, idx};
               if (free_blocks < COUNT_MAX) begin
                  free_blocks = free_blocks + CountW'(1);
               end
            end
         end
         OP_INIT: begin
            count = POOL_BYTES / live_block_bytes();
            if (count > MAX_BLOCKS) begin
               count = MAX_BLOCKS;
            end
            for (i = 0; i < count; i++) begin
               link_next[i] = (i + 1 < count) ? CountW'(i + 1) : CountW'(MAX_BLOCKS);
            end
            pool_blocks = CountW'(count);
            free_blocks = CountW'(count);
            head_idx    = (count > 0) ? '0 : CountW'(MAX_BLOCKS);
         end
         default: begin
         end
      endcase
      res.blocks_free = free_blocks;
   endtask

   task automatic check_field(input string field, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         mismatch_count++;
         $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      pool_result_type want;
      if (reset) begin
         block_bytes_reg = RESET_BLOCK_BYTES;
         head_idx        = CountW'(MAX_BLOCKS);
         free_blocks     = '0;
         pool_blocks     = '0;
         pending_results.delete();
         pending_count   = 0;
         mismatch_count  = 0;
         result_count    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display({"%0t: result with no request pending: ",
                         "index %0d offset %0d status %0d free %0d"},
                        $time, rsp_given_index, rsp_given_offset, rsp_status,
                        rsp_blocks_free);
            end else begin
               want = pending_results.pop_front();
               check_field("given_index", want.given_index, rsp_given_index);
               check_field("given_offset", want.given_offset, rsp_given_offset);
               check_field("status", want.status, rsp_status);
               check_field("blocks_free", want.blocks_free, rsp_blocks_free);
            end
         end
         if (csr_valid && csr_ready) begin
            block_bytes_reg = csr_block_bytes;
         end
         if (req_valid && !req_stall) begin
            pool_step(req_operation, req_block_index, want);
            pending_results.push_back(want);
         end
         pending_count = pending_results.size();
      end
   end

endmodule

FILE: sim/fixed_block_free_list_allocator_top_tb.sv
module fixed_block_free_list_allocator_top_tb;
   import fbfl_pkg::*;

   localparam int POOL_BYTES  = 4096;
   localparam int MAX_BLOCKS  = 256;
   localparam int ITEM_TARGET = 1350;
   localparam int FLOOD_FREES = 265;
   localparam int BURST_MAX   = 40;
   localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;

   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [OpW-1:0]      req_operation   = OP_ALLOC;
   logic [IndexW-1:0]   req_block_index = '0;

   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [IndexW-1:0]   rsp_given_index;
   logic [OffsetW-1:0]  rsp_given_offset;
   logic [StatusW-1:0]  rsp_status;
   logic [CountW-1:0]   rsp_blocks_free;

   logic                csr_valid       = 1'b0;
   logic                csr_ready;
   logic [SizeW-1:0]    csr_block_bytes = '0;

   int unsigned         mismatch_count;
   int unsigned         pending_count;
   int unsigned         result_count;

   int                  items_sent = 0;
   int                  pool_count = 0;
   logic [SizeW-1:0]    size_now   = RESET_BLOCK_BYTES;

   fixed_block_free_list_allocator_top #(
      .POOL_BYTES (POOL_BYTES),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_given_index  (rsp_given_index),
      .rsp_given_offset (rsp_given_offset),
      .rsp_status       (rsp_status),
      .rsp_blocks_free  (rsp_blocks_free),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_block_bytes  (csr_block_bytes)
   );

   fbfl_pool_shadow #(
      .POOL_BYTES (POOL_BYTES),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) pool_shadow (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_given_index  (rsp_given_index),
      .rsp_given_offset (rsp_given_offset),
      .rsp_status       (rsp_status),
      .rsp_blocks_free  (rsp_blocks_free),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_block_bytes  (csr_block_bytes),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .result_count     (result_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("fixed_block_free_list_allocator_top verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic int blocks_for(input logic [SizeW-1:0] bytes);
      int eff;
      int n;
      eff = int'(bytes);
      if (bytes < MIN_BLOCK_BYTES) begin
         eff = int'(MIN_BLOCK_BYTES);
      end
      n = POOL_BYTES / eff;
      return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
   endfunction

   function automatic logic [SizeW-1:0] pick_block_bytes();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SizeW'($urandom_range(1, 15));
         2: return 13'd16;
         3: return 13'd17;
         4: return 13'd4096;
         5: return SizeW'($urandom_range(4097, 8191));
         6: return 13'd8191;
         default: return SizeW'($urandom_range(16, 1024));
      endcase
   endfunction

   task automatic send_request(input logic [OpW-1:0] op, input logic [IndexW-1:0] idx);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_block_index <= idx;
      do @(posedge clock); while (req_stall);
      if (op != OP_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic send_init();
      send_request(OP_INIT, IndexW'($urandom));
      pool_count = blocks_for(size_now);
   endtask

   task automatic send_mixed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send_request(OP_ALLOC, IndexW'($urandom));
      end else if (r < 80) begin
         if (pool_count > 0) begin
            send_request(OP_FREE, IndexW'($urandom_range(0, pool_count - 1)));
         end else begin
            send_request(OP_FREE, IndexW'($urandom));
         end
      end else if (r < 93) begin
         send_request(OP_FREE, IndexW'($urandom));
      end else if (r < 97) begin
         send_request(OP_UNUSED, IndexW'($urandom));
      end else begin
         send_init();
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_block_bytes(input logic [SizeW-1:0] bytes);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_block_bytes <= bytes;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      size_now = bytes;
   endtask

   // receiver: mostly short stalls, a few long, one very long hold to back up the input
   initial begin : rsp_side
      int run_len;
      int hold_len;
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         if ($urandom_range(0, 9) < 7) begin
            run_len = $urandom_range(1, 12);
         end else begin
            run_len = $urandom_range(40, 200);
         end
         repeat (run_len) @(negedge clock);
         if (!long_hold_done && result_count >= 100) begin
            hold_len       = 150;
            long_hold_done = 1'b1;
         end else if ($urandom_range(0, 9) < 8) begin
            hold_len = $urandom_range(1, 3);
         end else begin
            hold_len = $urandom_range(10, 40);
         end
         rsp_stall <= 1'b1;
         repeat (hold_len) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   initial begin : req_side
      int kind;
      int take;
      int i;
      int j;
      int tmp;
      int order [$];

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // size below minimum, requests before the pool exists, double free
      set_block_bytes(13'd5);
      send_request(OP_FREE, 8'd0);
      send_request(OP_ALLOC, 8'hFF);
      send_request(OP_UNUSED, 8'hAA);
      send_init();
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd255);
      send_request(OP_FREE, 8'd1);
      send_request(OP_FREE, 8'd1);
      send_request(OP_ALLOC, 8'd0);
      drain();

      // size change without init, then single-block pool
      set_block_bytes(13'd4096);
      send_request(OP_ALLOC, 8'd0);
      send_init();
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd1);
      send_request(OP_FREE, 8'd0);
      drain();

      // block larger than the page: empty pool
      set_block_bytes(13'd8191);
      send_init();
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd0);
      send_request(OP_UNUSED, 8'hFF);
      drain();

      // repeated frees push the free count to saturation
      set_block_bytes('0);
      send_init();
      repeat (FLOOD_FREES) send_request(OP_FREE, IndexW'($urandom));
      repeat (20) send_request(OP_ALLOC, IndexW'($urandom));

      while (items_sent < ITEM_TARGET) begin
         drain();
         if ($urandom_range(0, 6) != 0) begin
            set_block_bytes(pick_block_bytes());
         end
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // fresh pool: allocate a burst, return it in shuffled order
            send_init();
            take = 0;
            if (pool_count > 0) begin
               take = $urandom_range(1, (pool_count < BURST_MAX) ? pool_count : BURST_MAX);
            end
            repeat (take) send_request(OP_ALLOC, IndexW'($urandom));
            if (take == pool_count) begin
               repeat ($urandom_range(0, 2)) send_request(OP_ALLOC, IndexW'($urandom));
            end
            order.delete();
            for (i = 0; i < take; i++) begin
               order.push_back(i);
            end
            for (i = take - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (i = 0; i < take; i++) begin
               send_request(OP_FREE, IndexW'(order[i]));
            end
            repeat ($urandom_range(2, 12)) send_mixed();
         end else begin
            if (kind < 8) begin
               send_init();
            end
            repeat ($urandom_range(5, 40)) send_mixed();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("fixed_block_free_list_allocator_top verification clean");
      end else begin
         $display("fixed_block_free_list_allocator_top verification failed");
      end
      $finish;
   end

endmodule
